### sv/spb_pkg.sv
// Shared types, constants and arithmetic helpers of the sphere pair bearing core.
// No dependencies; every other file but spb_ifs imports this package.
package spb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q30_SH    = 30 - FRAC_BITS;
  localparam int OUT_W     = 19;
  localparam int KQ_BITS   = 31;
  localparam int NUM_W     = 48;
  localparam int DEN_W     = 32;

  typedef logic signed [35:0] ang_t;
  typedef logic signed [33:0] cw_t;
  typedef logic signed [31:0] trig_t;
  typedef logic signed [32:0] raw_t;
  typedef logic signed [31:0] kfac_t;
  typedef logic signed [48:0] vec_t;
  typedef logic signed [51:0] av_t;
  typedef logic [OUT_W-1:0]   brg_t;

  typedef struct packed {
    raw_t rx1;
    raw_t ry1;
    raw_t rx2;
    raw_t ry2;
  } raw4_t;

  localparam ang_t  Q30_PI      = 36'sd3373259426;
  localparam ang_t  Q30_HALF_PI = 36'sd1686629713;
  localparam ang_t  Q30_TWO_PI  = 36'sd6746518852;
  localparam cw_t   GAIN_INV    = 34'sd652032874;
  localparam kfac_t K_ONE       = 32'sd65536;
  localparam kfac_t K_MAX       = 32'sd2147483647;
  localparam logic [15:0] EPS_RESET = 16'd66;
  localparam brg_t  BEARING_MAX = 19'd411775;

  localparam logic [31:0] ATAN_TAB [11] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF
  };

  function automatic ang_t atan_step(input int i);
    if (i < 11) begin
      return ang_t'(ATAN_TAB[i[3:0]]);
    end
    return (ang_t'(1) <<< 30) >>> i;
  endfunction

  function automatic trig_t mul30(input trig_t a, input trig_t b);
    logic signed [63:0] p;
    p = a * b;
    return trig_t'(p >>> 30);
  endfunction

  function automatic vec_t scale_k(input raw_t r, input kfac_t k);
    logic signed [64:0] p;
    p = r * k;
    return vec_t'(p >>> 16);
  endfunction

  function automatic logic near_zero(input vec_t v, input ang_t e);
    logic signed [49:0] vv;
    logic signed [49:0] ee;
    vv = v;
    ee = e;
    return (vv <= ee) && (vv >= -ee);
  endfunction

  function automatic brg_t wrap_round(input ang_t z);
    ang_t w;
    w = z;
    if (w < 0) begin
      w = w + Q30_TWO_PI;
    end
    if (w >= Q30_TWO_PI) begin
      w = w - Q30_TWO_PI;
    end
    if (w < 0) begin
      w = '0;
    end
    w = w + (ang_t'(1) <<< (Q30_SH - 1));
    return w[Q30_SH+OUT_W-1:Q30_SH];
  endfunction

endpackage

### sv/spb_ifs.sv
// Handshake channel interfaces of the sphere pair bearing core: input, result
// and configuration write. No dependencies.
interface spb_in_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] lon_first;
  logic signed [17:0] lat_first;
  logic signed [18:0] lon_second;
  logic signed [17:0] lat_second;
  logic [17:0]        arc_distance;
  modport source(output valid, lon_first, lat_first, lon_second, lat_second, arc_distance,
                 input ready);
  modport sink(input valid, lon_first, lat_first, lon_second, lat_second, arc_distance,
               output ready);
endinterface

interface spb_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] bearing_from_first;
  logic [18:0] bearing_from_second;
  modport source(output valid, bearing_from_first, bearing_from_second, input ready);
  modport sink(input valid, bearing_from_first, bearing_from_second, output ready);
endinterface

interface spb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### sv/sphere_pair_bearing_core.sv
// Top level of the sphere pair bearing core: input stage, trig, divider, products,
// vector angle and output skid. Depends on spb_pkg, spb_ifs, spb_sincos, spb_atan2.
//
// The core accepts one point pair per cycle while its skid entry is empty and returns
// both initial great-circle bearings of every accepted beat. The path runs through
// the unrolled sine/cosine CORDIC, the 31-stage restoring divider that forms
// distance over sine of distance, the scaling multiply and the unrolled atan2
// CORDIC. A two-entry output register and skid stage decouple the sides; the
// pipeline holds whenever the skid entry is occupied. The tolerance register may
// be written only while no item is in flight.
module sphere_pair_bearing_core import spb_pkg::*; #(
  parameter int CORDIC_STEPS = 18
) (
  input logic        clk,
  input logic        rst_n,
  spb_cfg_if.sink    cfg_bus,
  spb_in_if.sink     in_bus,
  spb_out_if.source  out_bus
);

  localparam int SC_LAT  = CORDIC_STEPS + 4;
  localparam int DIV_LAT = KQ_BITS + 2;
  localparam int RAW_LAT = DIV_LAT - 3;
  localparam int ATN_LAT = CORDIC_STEPS + 1;
  localparam int TOT_LAT = SC_LAT + DIV_LAT + 1 + ATN_LAT;
  localparam int CMP_W   = DEN_W + KQ_BITS;

  logic        en;
  logic [15:0] eps_r;
  ang_t        eps_q;

  logic        s0_v_r;
  logic        s0_ap_r;
  logic        s0_dz_r;
  ang_t        lat1_r;
  ang_t        lat2_r;
  ang_t        dlon_r;
  ang_t        dist_r;
  logic [17:0] arc_r;
  ang_t        lat1_w;
  ang_t        lat2_w;
  ang_t        lon1_w;
  ang_t        lon2_w;
  ang_t        dist_w;
  ang_t        dpi_w;

  logic        v_r  [TOT_LAT];
  logic        ap_r [TOT_LAT];
  logic [17:0] da_r [SC_LAT];
  logic        dz_r [SC_LAT];

  trig_t s1, c1, s2, c2, sd, cd, sdist, cdist;

  logic [NUM_W-1:0]   dv_rem_r [KQ_BITS+1];
  logic [DEN_W-1:0]   dv_d_r   [KQ_BITS+1];
  logic [KQ_BITS-1:0] dv_q_r   [KQ_BITS+1];
  logic               dv_neg_r [KQ_BITS+1];
  logic               dv_sat_r [KQ_BITS+1];
  logic               dv_dz_r  [KQ_BITS+1];
  logic [NUM_W-1:0]   num_w;
  logic [DEN_W-1:0]   dmag_w;
  kfac_t              k_r;

  trig_t pa_r, pb_r, pc_r, pe_r, cd1_r;
  trig_t pa2_r, pb2_r, pc2_r, pe2_r, pf_r, pg_r;
  raw4_t raw_r;
  raw4_t rw_r [RAW_LAT];

  vec_t ex1_r, ey1_r, ex2_r, ey2_r;
  logic [1:0] zf_r [ATN_LAT];
  ang_t z1_w, z2_w;

  logic fin_v;
  brg_t fin_b1, fin_b2;
  logic out_v_r, sk_v_r;
  brg_t out_b1_r, out_b2_r, sk_b1_r, sk_b2_r;

  assign en = !sk_v_r;
  assign in_bus.ready  = en;
  assign cfg_bus.ready = 1'b1;
  assign eps_q = ang_t'({20'b0, eps_r}) <<< Q30_SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_bus.valid) begin
      eps_r <= cfg_bus.data;
    end
  end

  always_comb begin
    lon1_w = ang_t'(in_bus.lon_first) <<< Q30_SH;
    lon2_w = ang_t'(in_bus.lon_second) <<< Q30_SH;
    lat1_w = ang_t'(in_bus.lat_first) <<< Q30_SH;
    lat2_w = ang_t'(in_bus.lat_second) <<< Q30_SH;
    dist_w = ang_t'({18'b0, in_bus.arc_distance}) <<< Q30_SH;
    dpi_w  = dist_w - Q30_PI;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r  <= lat1_w;
      lat2_r  <= lat2_w;
      dlon_r  <= lon2_w - lon1_w;
      dist_r  <= dist_w;
      arc_r   <= in_bus.arc_distance;
      s0_ap_r <= (dpi_w <= eps_q) && (dpi_w >= -eps_q);
      s0_dz_r <= (in_bus.arc_distance == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      for (int i = 0; i < TOT_LAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      s0_v_r <= in_bus.valid;
      v_r[0] <= s0_v_r;
      for (int i = 1; i < TOT_LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap_r[0] <= s0_ap_r;
      for (int i = 1; i < TOT_LAT; i++) begin
        ap_r[i] <= ap_r[i-1];
      end
      da_r[0] <= arc_r;
      dz_r[0] <= s0_dz_r;
      for (int i = 1; i < SC_LAT; i++) begin
        da_r[i] <= da_r[i-1];
        dz_r[i] <= dz_r[i-1];
      end
    end
  end

  spb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
    .clk(clk), .en(en), .z_in(lat1_r), .sin_o(s1), .cos_o(c1)
  );
  spb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
    .clk(clk), .en(en), .z_in(lat2_r), .sin_o(s2), .cos_o(c2)
  );
  spb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
    .clk(clk), .en(en), .z_in(dlon_r), .sin_o(sd), .cos_o(cd)
  );
  spb_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dist (
    .clk(clk), .en(en), .z_in(dist_r), .sin_o(sdist), .cos_o(cdist)
  );

  assign num_w  = {da_r[SC_LAT-1], 30'b0};
  assign dmag_w = sdist[DEN_W-1] ? DEN_W'(-sdist) : DEN_W'(sdist);

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= num_w;
      dv_d_r[0]   <= dmag_w;
      dv_q_r[0]   <= '0;
      dv_neg_r[0] <= sdist[DEN_W-1];
      dv_sat_r[0] <= {{(CMP_W-NUM_W){1'b0}}, num_w} >= {dmag_w, {KQ_BITS{1'b0}}};
      dv_dz_r[0]  <= dz_r[SC_LAT-1];
    end
  end

  for (genvar j = 0; j < KQ_BITS; j++) begin : g_div
    localparam int B = KQ_BITS - 1 - j;
    logic [CMP_W-1:0] sub_w;
    logic             ge_w;
    always_comb begin
      sub_w = {{KQ_BITS{1'b0}}, dv_d_r[j]} << B;
      ge_w  = {{(CMP_W-NUM_W){1'b0}}, dv_rem_r[j]} >= sub_w;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1] <= ge_w ? dv_rem_r[j] - sub_w[NUM_W-1:0] : dv_rem_r[j];
        dv_q_r[j+1]   <= ge_w ? dv_q_r[j] | (KQ_BITS'(1) << B) : dv_q_r[j];
        dv_d_r[j+1]   <= dv_d_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
        dv_sat_r[j+1] <= dv_sat_r[j];
        dv_dz_r[j+1]  <= dv_dz_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_dz_r[KQ_BITS]) begin
        k_r <= K_ONE;
      end else if (dv_sat_r[KQ_BITS]) begin
        k_r <= dv_neg_r[KQ_BITS] ? -K_MAX : K_MAX;
      end else if (dv_neg_r[KQ_BITS]) begin
        k_r <= -kfac_t'({1'b0, dv_q_r[KQ_BITS]});
      end else begin
        k_r <= kfac_t'({1'b0, dv_q_r[KQ_BITS]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= mul30(c2, sd);
      pb_r  <= mul30(c1, s2);
      pc_r  <= mul30(s1, c2);
      pe_r  <= mul30(c1, sd);
      cd1_r <= cd;
      pf_r  <= mul30(pc_r, cd1_r);
      pg_r  <= mul30(pb_r, cd1_r);
      pa2_r <= pa_r;
      pb2_r <= pb_r;
      pc2_r <= pc_r;
      pe2_r <= pe_r;
      raw_r.rx1 <= raw_t'(pa2_r);
      raw_r.ry1 <= raw_t'(pb2_r) - raw_t'(pf_r);
      raw_r.rx2 <= -raw_t'(pe2_r);
      raw_r.ry2 <= raw_t'(pc2_r) - raw_t'(pg_r);
      rw_r[0] <= raw_r;
      for (int i = 1; i < RAW_LAT; i++) begin
        rw_r[i] <= rw_r[i-1];
      end
      ex1_r <= scale_k(rw_r[RAW_LAT-1].rx1, k_r);
      ey1_r <= scale_k(rw_r[RAW_LAT-1].ry1, k_r);
      ex2_r <= scale_k(rw_r[RAW_LAT-1].rx2, k_r);
      ey2_r <= scale_k(rw_r[RAW_LAT-1].ry2, k_r);
      zf_r[0] <= {near_zero(ex2_r, eps_q) && near_zero(ey2_r, eps_q),
                  near_zero(ex1_r, eps_q) && near_zero(ey1_r, eps_q)};
      for (int i = 1; i < ATN_LAT; i++) begin
        zf_r[i] <= zf_r[i-1];
      end
    end
  end

  spb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_first (
    .clk(clk), .en(en), .east(ex1_r), .north(ey1_r), .ang_o(z1_w)
  );
  spb_atan2 #(.STEPS(CORDIC_STEPS)) u_at_second (
    .clk(clk), .en(en), .east(ex2_r), .north(ey2_r), .ang_o(z2_w)
  );

  assign fin_v  = v_r[TOT_LAT-1];
  assign fin_b1 = (ap_r[TOT_LAT-1] || zf_r[ATN_LAT-1][0]) ? '0 : wrap_round(z1_w);
  assign fin_b2 = (ap_r[TOT_LAT-1] || zf_r[ATN_LAT-1][1]) ? '0 : wrap_round(z2_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (out_bus.ready) begin
        sk_v_r <= 1'b0;
      end
    end else if (fin_v) begin
      if (!out_v_r || out_bus.ready) begin
        out_v_r <= 1'b1;
      end else begin
        sk_v_r <= 1'b1;
      end
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (out_bus.ready) begin
        out_b1_r <= sk_b1_r;
        out_b2_r <= sk_b2_r;
      end
    end else if (fin_v) begin
      if (!out_v_r || out_bus.ready) begin
        out_b1_r <= fin_b1;
        out_b2_r <= fin_b2;
      end else begin
        sk_b1_r <= fin_b1;
        sk_b2_r <= fin_b2;
      end
    end
  end

  assign out_bus.valid               = out_v_r;
  assign out_bus.bearing_from_first  = out_b1_r;
  assign out_bus.bearing_from_second = out_b2_r;

endmodule

### sv/spb_sincos.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q30 angle.
// Depends on spb_pkg. The pipeline advances only while en is high.
module spb_sincos import spb_pkg::*; #(
  parameter int STEPS = 18
) (
  input  logic  clk,
  input  logic  en,
  input  ang_t  z_in,
  output trig_t sin_o,
  output trig_t cos_o
);

  ang_t  r1_r, r1_nxt;
  ang_t  r2_r, r2_nxt;
  ang_t  z0_nxt;
  logic  neg0_nxt;
  ang_t  z_r   [STEPS+1];
  cw_t   x_r   [STEPS+1];
  cw_t   y_r   [STEPS+1];
  logic  neg_r [STEPS+1];
  trig_t sin_r;
  trig_t cos_r;

  always_comb begin
    if (z_in >= Q30_TWO_PI) begin
      r1_nxt = z_in - Q30_TWO_PI;
    end else if (z_in <= -Q30_TWO_PI) begin
      r1_nxt = z_in + Q30_TWO_PI;
    end else begin
      r1_nxt = z_in;
    end
    if (r1_r > Q30_PI) begin
      r2_nxt = r1_r - Q30_TWO_PI;
    end else if (r1_r < -Q30_PI) begin
      r2_nxt = r1_r + Q30_TWO_PI;
    end else begin
      r2_nxt = r1_r;
    end
    if (r2_r > Q30_HALF_PI) begin
      z0_nxt   = r2_r - Q30_PI;
      neg0_nxt = 1'b1;
    end else if (r2_r < -Q30_HALF_PI) begin
      z0_nxt   = r2_r + Q30_PI;
      neg0_nxt = 1'b1;
    end else begin
      z0_nxt   = r2_r;
      neg0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r     <= r1_nxt;
      r2_r     <= r2_nxt;
      z_r[0]   <= z0_nxt;
      neg_r[0] <= neg0_nxt;
      x_r[0]   <= GAIN_INV;
      y_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_step(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_step(i);
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= trig_t'(neg_r[STEPS] ? -y_r[STEPS] : y_r[STEPS]);
      cos_r <= trig_t'(neg_r[STEPS] ? -x_r[STEPS] : x_r[STEPS]);
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### sv/spb_atan2.sv
// Pipelined vectoring-mode CORDIC giving the clockwise-from-north angle of a vector.
// Depends on spb_pkg. The pipeline advances only while en is high.
module spb_atan2 import spb_pkg::*; #(
  parameter int STEPS = 18
) (
  input  logic clk,
  input  logic en,
  input  vec_t east,
  input  vec_t north,
  output ang_t ang_o
);

  av_t  x_r [STEPS+1];
  av_t  y_r [STEPS+1];
  ang_t z_r [STEPS+1];
  av_t  xe;
  av_t  yn;

  assign xe = av_t'(north);
  assign yn = av_t'(east);

  always_ff @(posedge clk) begin
    if (en) begin
      if (xe < 0) begin
        if (yn >= 0) begin
          x_r[0] <= yn;
          y_r[0] <= -xe;
          z_r[0] <= Q30_HALF_PI;
        end else begin
          x_r[0] <= -yn;
          y_r[0] <= xe;
          z_r[0] <= -Q30_HALF_PI;
        end
      end else begin
        x_r[0] <= xe;
        y_r[0] <= yn;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_step(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_step(i);
        end
      end
    end
  end

  assign ang_o = z_r[STEPS];

endmodule

### sv/spb_chk.sv
// Port-level assertions for the sphere pair bearing core, bound to its top level.
// Depends on spb_pkg and sphere_pair_bearing_core.
module spb_chk import spb_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input brg_t brg_first,
  input brg_t brg_second
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(brg_first) && $stable(brg_second))
    else $error("Stalled result beat changed or vanished.");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (brg_first <= BEARING_MAX) && (brg_second <= BEARING_MAX))
    else $error("Bearing outside of one full turn.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("Input held off without a stalled result beat.");

endmodule

bind sphere_pair_bearing_core spb_chk u_spb_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .brg_first(out_bus.bearing_from_first),
  .brg_second(out_bus.bearing_from_second)
);

### verif/testbench.sv
// Self-checking testbench of sphere_pair_bearing_core: drives point pairs and
// tolerance writes, predicts both bearings in fixed point and compares every beat.
// Depends on spb_pkg, spb_ifs and the core RTL.
module testbench;
  import spb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [18:0] b1;
    logic [18:0] b2;
  } brg_pair_t;

  localparam int STEPS = 18;
  localparam int LATENCY = 2 * STEPS + 41;
  localparam int DRAIN = LATENCY + 40;
  localparam longint P_PI = 64'sd3373259426;
  localparam longint P_HALF = 64'sd1686629713;
  localparam longint P_TWO = 64'sd6746518852;

  logic clk = 0;
  logic rst_n = 0;
  spb_cfg_if cfg_bus();
  spb_in_if in_bus();
  spb_out_if out_bus();

  sphere_pair_bearing_core #(.CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_bus(cfg_bus), .in_bus(in_bus), .out_bus(out_bus)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  brg_pair_t bearing_q[$];
  longint tol_q16 = 66;
  int mismatches = 0;
  bit quiet_phase = 0;

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    longint tab[11] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF};
    if (i < 11) return tab[i];
    return (64'sd1 << 30) >>> i;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic void sin_cos(input longint z0, output longint s, output longint c);
    longint x, y, z, nx;
    bit neg;
    x = 64'sd652032874; y = 0; z = z0 % P_TWO; neg = 0;
    if (z > P_PI) z -= P_TWO;
    if (z < -P_PI) z += P_TWO;
    if (z > P_HALF) begin z -= P_PI; neg = 1; end
    else if (z < -P_HALF) begin z += P_PI; neg = 1; end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= arctan_step(i);
      end else begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += arctan_step(i);
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function automatic logic [18:0] heading(longint east, longint north, longint e);
    longint x, y, z, nx;
    if ((east < 0 ? -east : east) <= e && (north < 0 ? -north : north) <= e) return '0;
    x = north; y = east; z = 0;
    if (x < 0) begin
      if (y >= 0) begin nx = y; y = -x; z = P_HALF; end
      else begin nx = -y; y = x; z = -P_HALF; end
      x = nx;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += arctan_step(i);
      end else begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= arctan_step(i);
      end
      x = nx;
    end
    if (z < 0) z += P_TWO;
    if (z >= P_TWO) z -= P_TWO;
    if (z < 0) z = 0;
    z += 64'sd8192;
    return 19'(z >>> 14);
  endfunction

  function automatic brg_pair_t predict_bearings(logic signed [18:0] lo1,
      logic signed [17:0] la1, logic signed [18:0] lo2, logic signed [17:0] la2,
      logic [17:0] d);
    brg_pair_t r;
    longint lat1, lat2, dl, arc, e, s1, c1, s2, c2, sd, cd, sx, cx, k;
    lat1 = longint'(la1) <<< 14;
    lat2 = longint'(la2) <<< 14;
    dl = (longint'(lo2) - longint'(lo1)) <<< 14;
    arc = longint'({1'b0, d}) <<< 14;
    e = tol_q16 <<< 14;
    r.b1 = '0; r.b2 = '0;
    if (((arc - P_PI) < 0 ? P_PI - arc : arc - P_PI) <= e) return r;
    sin_cos(lat1, s1, c1);
    sin_cos(lat2, s2, c2);
    sin_cos(dl, sd, cd);
    sin_cos(arc, sx, cx);
    if (arc == 0) k = 65536;
    else if (sx == 0) k = 64'sd2147483647;
    else begin
      k = (arc * 65536) / sx;
      if (k > 64'sd2147483647) k = 64'sd2147483647;
      if (k < -64'sd2147483647) k = -64'sd2147483647;
    end
    r.b1 = heading((qmul(c2, sd) * k) >>> 16,
                   ((qmul(c1, s2) - qmul(qmul(s1, c2), cd)) * k) >>> 16, e);
    r.b2 = heading((-qmul(c1, sd) * k) >>> 16,
                   ((qmul(c2, s1) - qmul(qmul(s2, c1), cd)) * k) >>> 16, e);
    return r;
  endfunction

  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 16);
  endfunction

  initial begin
    cfg_bus.valid = 0; cfg_bus.data = 0;
    in_bus.valid = 0; in_bus.lon_first = 0; in_bus.lat_first = 0;
    in_bus.lon_second = 0; in_bus.lat_second = 0; in_bus.arc_distance = 0;
    out_bus.ready = 0;
  end

  always @(posedge clk) begin
    if (rst_n) out_bus.ready <= !idle_now();
  end

  always @(posedge clk) begin
    brg_pair_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (bearing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d %0d",
          out_bus.bearing_from_first, out_bus.bearing_from_second);
      end else begin
        want = bearing_q.pop_front();
        if (want.b1 !== out_bus.bearing_from_first ||
            want.b2 !== out_bus.bearing_from_second) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d, got %0d %0d", want.b1, want.b2,
              out_bus.bearing_from_first, out_bus.bearing_from_second);
        end
      end
    end
  end

  task automatic send_pair(int lo1, int la1, int lo2, int la2, int d);
    while (idle_now()) begin
      in_bus.valid <= 0;
      @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.lon_first <= 19'(lo1); in_bus.lat_first <= 18'(la1);
    in_bus.lon_second <= 19'(lo2); in_bus.lat_second <= 18'(la2);
    in_bus.arc_distance <= 18'(d);
    bearing_q.push_back(predict_bearings(19'(lo1), 18'(la1), 19'(lo2), 18'(la2), 18'(d)));
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic write_tolerance(int v);
    in_bus.valid <= 0;
    while (bearing_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_bus.valid <= 1;
    cfg_bus.data <= 16'(v);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 0;
    tol_q16 = longint'(v);
  endtask

  task automatic test_directed();
    send_pair(0, 0, 0, 0, 0);
    send_pair(205887, 102944, -205887, -102944, 205887);
    send_pair(-205887, -102944, 205887, 102944, 0);
    send_pair(0, 0, 205887, 0, 205887);
    send_pair(0, 0, 102944, 0, 102944);
    send_pair(0, 102944, 0, -102944, 205887);
    send_pair(0, 0, 0, 50, 50);
    send_pair(100, 0, 100, 0, 0);
    send_pair(0, -102944, 0, 102944, 205900);
    send_pair(-262144, -131072, 262143, 131071, 262143);
    send_pair(262143, 131071, -262144, -131072, 0);
    send_pair(0, 0, 0, 0, 262143);
    send_pair(-1, -1, -1, -1, 1);
    send_pair(1000, 2000, -3000, 4000, 411774 & 262143);
  endtask

  task automatic random_pair();
    int lo1, la1, lo2, la2, d, m;
    m = $urandom_range(9);
    lo1 = $urandom_range(411774) - 205887;
    la1 = $urandom_range(205888) - 102944;
    lo2 = $urandom_range(411774) - 205887;
    la2 = $urandom_range(205888) - 102944;
    d = $urandom_range(205887);
    if (m == 0) begin
      lo1 = int'($urandom) >>> 13; la1 = int'($urandom) >>> 14;
      lo2 = int'($urandom) >>> 13; la2 = int'($urandom) >>> 14;
      d = $urandom_range(262143);
    end else if (m == 1) begin
      d = 205887 + $urandom_range(400) - 200;
    end else if (m == 2) begin
      lo2 = lo1 + $urandom_range(60) - 30; la2 = la1 + $urandom_range(60) - 30;
      d = $urandom_range(80);
    end
    send_pair(lo1, la1, lo2, la2, d);
  endtask

  task automatic test_random(int n, bit calm);
    quiet_phase = calm;
    repeat (n) random_pair();
    quiet_phase = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(400, 0);
    test_random(300, 1);
    write_tolerance(0);
    test_directed();
    test_random(250, 0);
    write_tolerance(65535);
    test_random(150, 0);
    write_tolerance(21845);
    test_random(150, 0);
    write_tolerance(43690);
    test_random(100, 0);
    write_tolerance(66);
    test_random(150, 0);
    in_bus.valid <= 0;
    while (bearing_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end
endmodule
